@@ rtl/edaf_pkg.sv @@
// Shared types, sizes and pixel arithmetic for the edge-directed antialias filter.
package edaf_pkg;

	localparam int IMG_WIDTH    = 1024;
	localparam int IMG_HEIGHT   = 1024;
	localparam int COL_W        = $clog2(IMG_WIDTH);
	localparam int ROW_W        = $clog2(IMG_HEIGHT);
	localparam logic [9:0] THRESH_RESET = 10'd30;

	typedef struct packed {
		logic [23:0] pixel_in;
		logic        frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [23:0] pixel_out;
		logic [9:0]  out_row;
		logic [9:0]  out_col;
		logic        smoothed;
		logic        last;
	} pix_out_t;

	// One line buffer entry: the column's pixel from two rows up and one row up
	typedef struct packed {
		logic [23:0] older;
		logic [23:0] prior;
	} line_ent_t;

	// Sum of absolute per-channel differences of two RGB pixels
	function automatic logic [9:0] pair_diff(input logic [23:0] a, input logic [23:0] b);
		logic [7:0] x;
		logic [7:0] y;
		logic [9:0] s;
		s = '0;
		for (int k = 0; k < 3; k++) begin
			x = a[8*k +: 8];
			y = b[8*k +: 8];
			s = s + 10'((x > y) ? (x - y) : (y - x));
		end
		return s;
	endfunction

	// Per channel: mean of the four cross neighbors, then mean with the center
	function automatic logic [23:0] blend(input logic [23:0] ctr, input logic [23:0] rt,
			input logic [23:0] dn, input logic [23:0] up, input logic [23:0] lf);
		logic [9:0]  s4;
		logic [8:0]  m2;
		logic [23:0] res;
		res = '0;
		for (int k = 0; k < 3; k++) begin
			s4 = 10'(rt[8*k +: 8]) + 10'(dn[8*k +: 8]) + 10'(up[8*k +: 8]) + 10'(lf[8*k +: 8]);
			m2 = 9'(s4[9:2]) + 9'(ctr[8*k +: 8]);
			res[8*k +: 8] = m2[8:1];
		end
		return res;
	endfunction

endpackage

@@ rtl/edge_directed_antialias_filter.sv @@
// Edge-directed antialias filter: line buffer RAM, stage 1, stage 2, output register.
//
// Pixels enter in raster order on the pix channel (pix_valid / pix_stall / pix_data);
// frame_start on a beat restarts the row and column counters at that pixel.
// Taking pixel (r, c) produces the result for (r-1, c) on the res channel
// (res_valid / res_stall / res_data) with its row, column and a smoothed flag.
// Row 0 pixels give no result; pixels of the last row give two beats: (r-1, c),
// then (r, c) itself as a border pass-through. last marks the final beat of a pixel.
// The threshold register is written over cfg (cfg_valid / cfg_ready / cfg_data);
// cfg_ready is always high and the write is meant for idle periods.
// Throughput: one pixel per clock while res_stall is low, set by one read and one
// write of the line RAM per beat; a last-row pixel gives two beats and stalls the
// pixel behind it until its second beat is loaded. A result passes stage 1 and the RAM
// read at its pixel's accepting edge, then the difference stage, then the output register.
// Both line buffers share one RAM of IMG_WIDTH entries of 48 bits; the right-hand
// neighbor is read one column ahead and becomes the next pixel's column entry.
// Reset clears the counters, pipeline valids and sets the threshold to 30; the RAM
// is not cleared (its contents are defined once the first two rows have passed).
// A stall on res holds the output register; the stall backs up through the
// pipeline to pix_stall, and no beat is lost or repeated.
module edge_directed_antialias_filter
	import edaf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pix_valid,
	output logic     pix_stall,
	input  pix_in_t  pix_data,
	output logic     res_valid,
	input  logic     res_stall,
	output pix_out_t res_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [9:0] cfg_data
);

	// Line buffer RAM and its read register
	line_ent_t line_mem [IMG_WIDTH];
	line_ent_t rd_q;

	logic [9:0]       thresh_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [23:0]      left_q;
	logic [23:0]      prior0_q;

	// Stage 1: accepted pixel with its neighbors, right neighbor arriving in rd_q
	logic             valid_s1;
	logic [23:0]      pix_s1, ctr_s1, up_s1, lf_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic             intr_s1, has_s1, two_s1;

	// Stage 2: pair differences and blended value
	logic             valid_s2;
	logic [9:0]       diff_s2 [4];
	logic [23:0]      blend_s2, ctr_s2, pix_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic             intr_s2, two_s2;
	logic             phase_q;

	// Output register
	logic             res_valid_q;
	pix_out_t         res_q;

	logic             in_acc, s1_adv, s2_adv, out_load, out_take, is_edge;
	logic [COL_W-1:0] c_eff, rd_addr;
	logic [ROW_W-1:0] r_eff;
	logic [23:0]      cur_prior, right_px;
	pix_out_t         res_next;

	// Handshake and flow control
	assign out_take  = res_valid_q && !res_stall;
	assign out_load  = valid_s2 && (!res_valid_q || out_take);
	assign s2_adv    = out_load && (!two_s2 || phase_q);
	assign s1_adv    = valid_s1 && (!has_s1 || !valid_s2 || s2_adv);
	assign pix_stall = valid_s1 && !s1_adv;
	assign in_acc    = pix_valid && !pix_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Position of the incoming pixel and the look-ahead read address
	always_comb begin
		c_eff     = pix_data.frame_start ? '0 : col_q;
		r_eff     = pix_data.frame_start ? '0 : row_q;
		rd_addr   = (c_eff == COL_W'(IMG_WIDTH - 1)) ? '0 : c_eff + 1'b1;
		cur_prior = (c_eff == '0) ? prior0_q : rd_q.prior;
		right_px  = rd_q.prior;
	end

	// Line RAM: one read and one write per accepted beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			line_mem[c_eff] <= '{older: cur_prior, prior: pix_data.pixel_in};
			rd_q            <= line_mem[rd_addr];
		end
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// Position counters, left neighbor, column-0 shadow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (in_acc) begin
			left_q <= cur_prior;
			if (c_eff == COL_W'(IMG_WIDTH - 1)) begin
				col_q <= '0;
				row_q <= (r_eff == ROW_W'(IMG_HEIGHT - 1)) ? '0 : r_eff + 1'b1;
			end else begin
				col_q <= c_eff + 1'b1;
				row_q <= r_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && c_eff == '0) begin
			prior0_q <= pix_data.pixel_in;
		end
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pix_data.pixel_in;
			ctr_s1  <= cur_prior;
			up_s1   <= rd_q.older;
			lf_s1   <= left_q;
			row_s1  <= r_eff;
			col_s1  <= c_eff;
			intr_s1 <= (r_eff >= ROW_W'(2)) && (c_eff != '0)
				&& (c_eff != COL_W'(IMG_WIDTH - 1));
			has_s1  <= (r_eff != '0);
			two_s1  <= (r_eff == ROW_W'(IMG_HEIGHT - 1));
		end
	end

	// Stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (s1_adv && has_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s2_adv) begin
				phase_q <= 1'b0;
			end else if (out_load) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_s1) begin
			diff_s2[0] <= pair_diff(right_px, pix_s1);
			diff_s2[1] <= pair_diff(right_px, up_s1);
			diff_s2[2] <= pair_diff(lf_s1, pix_s1);
			diff_s2[3] <= pair_diff(lf_s1, up_s1);
			blend_s2   <= blend(ctr_s1, right_px, pix_s1, up_s1, lf_s1);
			ctr_s2     <= ctr_s1;
			pix_s2     <= pix_s1;
			row_s2     <= row_s1;
			col_s2     <= col_s1;
			intr_s2    <= intr_s1;
			two_s2     <= two_s1;
		end
	end

	// Edge decision and result beat selection
	always_comb begin
		is_edge = intr_s2 && ((diff_s2[0] > thresh_q) || (diff_s2[1] > thresh_q)
			|| (diff_s2[2] > thresh_q) || (diff_s2[3] > thresh_q));
		if (phase_q) begin
			res_next.pixel_out = pix_s2;
			res_next.out_row   = 10'(row_s2);
			res_next.smoothed  = 1'b0;
			res_next.last      = 1'b1;
		end else begin
			res_next.pixel_out = is_edge ? blend_s2 : ctr_s2;
			res_next.out_row   = 10'(row_s2 - 1'b1);
			res_next.smoothed  = is_edge;
			res_next.last      = !two_s2;
		end
		res_next.out_col = 10'(col_s2);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (out_take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res_next;
		end
	end

	// A smoothed beat never belongs to a border pixel
	a_smooth_interior: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.smoothed |->
			res_data.out_col != 10'd0 && res_data.out_row != 10'd0
			&& res_data.out_col != 10'(IMG_WIDTH - 1))
		else $error("smoothed beat on a border pixel");

	// Only the first beat of a last-row pixel is not marked last
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.last |-> res_data.out_row == 10'(IMG_HEIGHT - 2)
			&& !res_data.smoothed || res_data.out_row == 10'(IMG_HEIGHT - 2))
		else $error("non-last beat outside the row above the last");

	// The second-beat phase only exists while stage 2 holds a last-row pixel
	a_phase_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_s2 && two_s2)
		else $error("second beat pending without a last-row pixel");

endmodule
